### src/asr_pkg.sv
// Shared constants, types and helpers for the converter-sample servo regulator.
// Used by every module under src; depends on nothing else.
package asr_pkg;

	localparam int ADC_BITS = 24;
	localparam int LEVEL_W  = 24;
	localparam int SP_W     = 24;
	localparam int CENTER_W = 16;
	localparam int ANGLE_W  = 8;
	localparam int CMP_W    = 16;
	localparam int WORD_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int OUT_DATA_W = CMP_W + ANGLE_W + 2 * LEVEL_W;

	// error magnitude, digit-serial multiplier geometry
	localparam int ERR_W   = LEVEL_W + 2;
	localparam int MAG_W   = LEVEL_W + 1;
	localparam int DIG_W   = 5;
	localparam int STEPS   = MAG_W / DIG_W;
	localparam int CNT_W   = $clog2(STEPS);
	localparam int K_W     = 22;
	localparam int FRAC_W  = 32;
	localparam int Q_W     = MAG_W + K_W - FRAC_W;
	localparam int DROP_W  = FRAC_W - MAG_W;

	localparam logic [K_W-1:0] K_REGULATE = K_W'(2559148);
	localparam logic [K_W-1:0] K_BACKFILL = K_W'(1279574);

	localparam logic [LEVEL_W-1:0] ADC_MID = LEVEL_W'(2 ** (ADC_BITS - 1));

	localparam logic [2:0] CHAN_MASK       = 3'h7;
	localparam logic [2:0] CHAN_OXIDIZER   = 3'h3;
	localparam logic [2:0] CHAN_PRESSURANT = 3'h2;

	localparam logic signed [ANGLE_W-1:0] THETA_NEG  = -8'sd30;
	localparam logic signed [ANGLE_W-1:0] THETA_MAX  = 8'sd57;
	localparam logic signed [ANGLE_W-1:0] ANGLE_BASE = -8'sd57;
	localparam logic signed [ANGLE_W-1:0] ANGLE_IDLE = -8'sd90;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGULATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKFILL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 2'd3;

	typedef struct packed {
		logic start;
	} asr_mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} asr_mul_sts_t;

	// trunc(12.2 * m) = 12*m + floor(m/5); m/5 by reciprocal 205/1024, exact for m <= 90
	function automatic logic [10:0] servo_offset(input logic [6:0] m);
		logic [14:0] fifth;
		fifth = 15'(m) * 15'd205;
		return 11'({m, 3'b000}) + 11'({m, 2'b00}) + 11'(fifth[14:10]);
	endfunction

endpackage

### src/asr_serial_mul.sv
// Digit-serial unsigned multiplier: error magnitude times a Q0.32 gain,
// five bits of the magnitude per cycle, keeping only product bits from 2^32 up.
// Depends on asr_pkg.
module asr_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  asr_pkg::asr_mul_ctl_t       ctl,
	input  logic [asr_pkg::MAG_W-1:0]   mag,
	input  logic [asr_pkg::K_W-1:0]     k,
	output asr_pkg::asr_mul_sts_t       sts,
	output logic [asr_pkg::Q_W-1:0]     q
);
	import asr_pkg::*;

	logic [MAG_W-1:0]       mag_q;
	logic [K_W-1:0]         k_q;
	logic [K_W-1:0]         acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [K_W+DIG_W-1:0]   sum;

	assign sum = (K_W+DIG_W)'(acc_q) + (K_W+DIG_W)'(k_q) * (K_W+DIG_W)'(mag_q[DIG_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mag_q <= mag;
			k_q   <= k;
			acc_q <= '0;
		end else if (busy_q) begin
			// shift out the low digit: it never reaches bit 32 again
			acc_q <= sum[K_W+DIG_W-1:DIG_W];
			mag_q <= mag_q >> DIG_W;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign q = acc_q[K_W-1:DROP_W];

endmodule

### src/asr_servo_map.sv
// Turns the scaled error into a clamped servo angle and a pulse compare value.
// Pure logic; depends on asr_pkg.
module asr_servo_map (
	input  logic [asr_pkg::Q_W-1:0]             q,
	input  logic                                neg,
	input  logic                                regulate,
	input  logic                                backfill,
	input  logic [asr_pkg::CENTER_W-1:0]        center,
	output logic signed [asr_pkg::ANGLE_W-1:0]  angle,
	output logic [asr_pkg::CMP_W-1:0]           compare
);
	import asr_pkg::*;

	logic signed [ANGLE_W-1:0] theta;
	logic [6:0]                mag;
	logic [CMP_W:0]            diff;

	always_comb begin
		if (neg && (q != '0)) begin
			theta = THETA_NEG;
		end else if (q > Q_W'(THETA_MAX)) begin
			theta = THETA_MAX;
		end else begin
			theta = ANGLE_W'(q);
		end

		if (regulate || backfill) begin
			angle = ANGLE_BASE + theta;
		end else begin
			angle = ANGLE_IDLE;
		end

		// angle is never positive
		mag  = 7'(-angle);
		diff = {1'b0, center} - (CMP_W+1)'(servo_offset(mag));
		compare = diff[CMP_W] ? '0 : diff[CMP_W-1:0];
	end

endmodule

### src/adc_sample_servo_regulator.sv
// One sample at a time: a sample is taken only in idle, then passes the load, the
// five-step digit-serial multiply, the handoff and the output stages in turn.
// A finished result waits in the output register while the next sample is accepted.
// Reset (arst_n low, asynchronous) clears the levels, the configuration registers,
// the state and the valids.
// Configuration writes are taken every cycle (cfg_ready stays high).
module adc_sample_servo_regulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [asr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [asr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [asr_pkg::WORD_W-1:0]      s_axis_tdata,   // [31:0] adc_word
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] servo_compare, [23:16] servo_angle, [47:24] oxidizer_reading,
	// [71:48] pressurant_reading
	output logic [asr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import asr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]               state_q;
	logic signed [SP_W-1:0]   setpoint_q;
	logic                     regulate_q;
	logic                     backfill_q;
	logic [CENTER_W-1:0]      center_q;
	logic [LEVEL_W-1:0]       oxidizer_q;
	logic [LEVEL_W-1:0]       pressurant_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;

	logic                     in_fire;
	logic                     out_free;
	logic [2:0]               chan;
	logic [LEVEL_W-1:0]       data;
	logic [LEVEL_W-1:0]       ox_next;
	logic signed [ERR_W-1:0]  err;
	logic [ERR_W-1:0]         err_abs;
	logic [MAG_W-1:0]         mag;
	logic [K_W-1:0]           k;
	asr_mul_ctl_t             mul_ctl;
	asr_mul_sts_t             mul_sts;
	logic [Q_W-1:0]           q;
	logic signed [ANGLE_W-1:0] angle;
	logic [CMP_W-1:0]         compare;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign chan    = s_axis_tdata[2:0] & CHAN_MASK;
	assign data    = s_axis_tdata[WORD_W-1:8];
	assign ox_next = (chan == CHAN_OXIDIZER) ? data : oxidizer_q;

	// error against the level as it stands after this sample
	assign err     = ERR_W'(setpoint_q) - $signed({2'b00, ox_next}) + $signed({2'b00, ADC_MID});
	assign err_abs = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign mag     = err_abs[MAG_W-1:0];
	assign k       = regulate_q ? K_REGULATE : K_BACKFILL;
	assign mul_ctl.start = in_fire;

	asr_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mag    (mag),
		.k      (k),
		.sts    (mul_sts),
		.q      (q)
	);

	asr_servo_map u_map (
		.q        (q),
		.neg      (neg_q),
		.regulate (regulate_q),
		.backfill (backfill_q),
		.center   (center_q),
		.angle    (angle),
		.compare  (compare)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			regulate_q <= 1'b0;
			backfill_q <= 1'b0;
			center_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= cfg_data[SP_W-1:0];
				REG_REGULATE: regulate_q <= cfg_data[0];
				REG_BACKFILL: backfill_q <= cfg_data[0];
				REG_CENTER:   center_q   <= cfg_data[CENTER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oxidizer_q   <= '0;
			pressurant_q <= '0;
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			neg_q        <= 1'b0;
		end else begin
			// load a new result, or hold the waiting one until it is taken
			out_valid_q <= ((state_q == ST_OUT) && out_free) || (out_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (chan == CHAN_OXIDIZER) begin
							oxidizer_q <= data;
						end else if (chan == CHAN_PRESSURANT) begin
							pressurant_q <= data;
						end
						neg_q   <= err[ERR_W-1];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_data_q <= {pressurant_q, oxidizer_q, angle, compare};
		end
	end

endmodule

### test/tb_adc_sample_servo_regulator.sv
// Self-checking bench for the converter-sample servo regulator: drives converter words and
// register writes, predicts every servo command and compares it field by field.
// Depends on src/asr_pkg.sv and src/adc_sample_servo_regulator.sv.
module tb_adc_sample_servo_regulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  IDLE_PCT   = 36;
	localparam int  STALL_MAX  = 5000;
	localparam int  RAND_PHASES = 8;
	localparam int  PHASE_WORDS = 73;
	localparam longint MIDSCALE = 64'sd8388608;
	localparam longint GAIN_REGULATE = 64'sd2559148;
	localparam longint GAIN_BACKFILL = 64'sd1279574;

	typedef struct packed {
		logic [23:0]        pressurant_reading;
		logic [23:0]        oxidizer_reading;
		logic signed [7:0]  servo_angle;
		logic [15:0]        servo_compare;
	} servo_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [asr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [asr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [asr_pkg::WORD_W-1:0] s_axis_tdata = '0;    // [31:0] adc_word
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [15:0] servo_compare, [23:16] servo_angle, [47:24] oxidizer_reading,
	// [71:48] pressurant_reading
	logic [asr_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	// mirror of the block's registers and levels
	logic signed [23:0] setpoint_reg = '0;
	logic regulate_reg = 1'b0;
	logic backfill_reg = 1'b0;
	logic [15:0] center_reg = '0;
	logic [23:0] oxidizer_lvl = '0;
	logic [23:0] pressurant_lvl = '0;

	logic [31:0] adc_words[$];
	servo_cmd_t pending_commands[$];
	int words_loaded = 0;
	int words_accepted = 0;
	int errors = 0;
	int stall_cycles = 0;
	bit quiet = 1'b0;
	logic word_taken = 1'b0;

	adc_sample_servo_regulator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Store the sample, then run the control law on the stored oxidizer level.
	function automatic servo_cmd_t servo_command_for(input logic [31:0] word);
		servo_cmd_t cmd;
		longint err;
		longint mag;
		longint prod;
		int theta;
		int angle;
		int cmp;
		if (word[2:0] == asr_pkg::CHAN_OXIDIZER)
			oxidizer_lvl = word[31:8];
		else if (word[2:0] == asr_pkg::CHAN_PRESSURANT)
			pressurant_lvl = word[31:8];
		if (regulate_reg || backfill_reg) begin
			err = longint'(setpoint_reg) - (longint'(oxidizer_lvl) - MIDSCALE);
			mag = (err < 0) ? -err : err;
			prod = (mag * (regulate_reg ? GAIN_REGULATE : GAIN_BACKFILL)) >>> 32;
			if (err < 0 && prod != 0)
				theta = -30;
			else if (prod > 57)
				theta = 57;
			else
				theta = int'(prod);
			angle = -57 + theta;
		end else begin
			angle = -90;
		end
		// int division truncates toward zero, as 12.2 * angle must
		cmp = int'(center_reg) + (angle * 122) / 10;
		if (cmp < 0)
			cmp = 0;
		cmd.servo_compare = 16'(cmp);
		cmd.servo_angle = 8'(angle);
		cmd.oxidizer_reading = oxidizer_lvl;
		cmd.pressurant_reading = pressurant_lvl;
		return cmd;
	endfunction

	function automatic logic [31:0] sample_word(input logic [23:0] data, input logic [2:0] chan);
		return {data, 5'h1f, chan};
	endfunction

	// Oxidizer most often; most data lie near the setpoint so theta covers its range.
	function automatic logic [31:0] random_word();
		logic [23:0] data;
		logic [2:0] chan;
		int pick;
		int offset;
		pick = $urandom_range(99);
		if (pick < 45)
			chan = asr_pkg::CHAN_OXIDIZER;
		else if (pick < 65)
			chan = asr_pkg::CHAN_PRESSURANT;
		else
			chan = 3'($urandom_range(7));
		if ($urandom_range(99) < 60) begin
			offset = int'($urandom_range(223000)) - 3000;
			data = 24'(setpoint_reg) + 24'h800000 - 24'(offset);
		end else begin
			data = 24'($urandom);
		end
		return {data, 5'($urandom), chan};
	endfunction

	task automatic queue_word(input logic [31:0] word);
		adc_words.push_back(word);
		words_loaded++;
	endtask

	task automatic write_reg(input logic [asr_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			asr_pkg::REG_SETPOINT: setpoint_reg = value;
			asr_pkg::REG_REGULATE: regulate_reg = value[0];
			asr_pkg::REG_BACKFILL: backfill_reg = value[0];
			asr_pkg::REG_CENTER:   center_reg = value[15:0];
			default: ;
		endcase
	endtask

	// Upper bits of the narrow registers carry noise; the block must ignore them.
	task automatic program_servo(input logic [23:0] sp, input bit reg_en, input bit bf_en,
			input logic [15:0] center);
		write_reg(asr_pkg::REG_SETPOINT, sp);
		write_reg(asr_pkg::REG_REGULATE, {23'($urandom), reg_en});
		write_reg(asr_pkg::REG_BACKFILL, {23'($urandom), bf_en});
		write_reg(asr_pkg::REG_CENTER, {8'($urandom), center});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (words_accepted != words_loaded || pending_commands.size() != 0);
	endtask

	// request driver: hold a word until taken, then maybe idle
	always @(negedge clk) begin
		if (!s_axis_tvalid || word_taken) begin
			if (adc_words.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				s_axis_tdata <= adc_words.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		servo_cmd_t got;
		servo_cmd_t want;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			pending_commands.push_back(servo_command_for(s_axis_tdata));
			words_accepted++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_commands.size() == 0) begin
				$error("servo command with no sample pending: %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_commands.pop_front();
				if (got.servo_compare !== want.servo_compare) begin
					$error("servo_compare expected %0d got %0d",
						want.servo_compare, got.servo_compare);
					errors++;
				end
				if (got.servo_angle !== want.servo_angle) begin
					$error("servo_angle expected %0d got %0d",
						want.servo_angle, got.servo_angle);
					errors++;
				end
				if (got.oxidizer_reading !== want.oxidizer_reading) begin
					$error("oxidizer_reading expected %h got %h",
						want.oxidizer_reading, got.oxidizer_reading);
					errors++;
				end
				if (got.pressurant_reading !== want.pressurant_reading) begin
					$error("pressurant_reading expected %h got %h",
						want.pressurant_reading, got.pressurant_reading);
					errors++;
				end
			end
		end
	end

	// watchdog: count cycles in which no request moves on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [23:0] sp;
		logic [15:0] center;
		logic [1:0] modes;
		int pick;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// regulating mode around midscale: clamps, zero theta, small negative error
		program_servo(24'd0, 1'b1, 1'b0, 16'd700);
		queue_word(sample_word(24'h000000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'hffffff, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'h800000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'h800000 + 24'd1000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'h800000 - 24'd30000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'h800000 - 24'd95000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'hffffff, asr_pkg::CHAN_PRESSURANT));
		queue_word(sample_word(24'h000000, asr_pkg::CHAN_PRESSURANT));
		// unused channels leave both levels alone
		for (int c = 0; c < 8; c++)
			if (3'(c) != asr_pkg::CHAN_OXIDIZER && 3'(c) != asr_pkg::CHAN_PRESSURANT)
				queue_word(sample_word(24'hffffff, 3'(c)));
		wait_drained();

		// no mode: fixed idle angle against the top center
		program_servo(24'h800000, 1'b0, 1'b0, 16'hffff);
		queue_word(sample_word(24'h000000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'habcdef, 3'd7));
		wait_drained();

		// both modes: regulating gain wins; zero center saturates the compare value
		program_servo(24'h7fffff, 1'b1, 1'b1, 16'd0);
		queue_word(sample_word(24'hffffff, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'h000000, asr_pkg::CHAN_OXIDIZER));
		wait_drained();

		program_servo(24'd0, 1'b0, 1'b1, 16'd1098);
		queue_word(sample_word(24'h800000 - 24'd100000, asr_pkg::CHAN_OXIDIZER));
		queue_word(sample_word(24'h123456, 3'd5));
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0)
				sp = 24'h800000;
			else if (p == 1)
				sp = 24'h7fffff;
			else if ($urandom_range(3) == 0)
				sp = 24'($urandom_range(4000)) - 24'd2000;
			else
				sp = 24'($urandom);
			pick = $urandom_range(3);
			center = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hffff :
				(pick == 2) ? 16'($urandom_range(1200)) : 16'($urandom);
			modes = (p < 4) ? 2'(p) : 2'($urandom);
			program_servo(sp, modes[0], modes[1], center);
			quiet = (p == 2);
			for (int i = 0; i < PHASE_WORDS; i++)
				queue_word(random_word());
			// hold further writes until every command of this setting is back
			wait_drained();
			quiet = 1'b0;
		end

		repeat (20) @(negedge clk);
		if (errors == 0 && pending_commands.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### sim.f
src/asr_pkg.sv
src/asr_serial_mul.sv
src/asr_servo_map.sv
src/adc_sample_servo_regulator.sv
test/tb_adc_sample_servo_regulator.sv
